### rtl/core/assert_macros.svh
// assertion helpers used by gaussian_mixture_2d_eval
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/core/gme_pkg.sv
`default_nettype none
package gme_pkg;

   // table geometry
   localparam int NUM_COMPONENTS = 8;
   localparam int WORDS_PER      = 6;
   localparam int COMP_BITS      = $clog2(NUM_COMPONENTS);
   localparam int LIMIT_BITS     = $clog2(NUM_COMPONENTS + 1);
   localparam int TABLE_DEPTH    = NUM_COMPONENTS * WORDS_PER;
   localparam int ADDR_BITS      = $clog2(TABLE_DEPTH);
   localparam int WORD_BITS      = 32;
   localparam int SEL_BITS       = 3;

   // number formats
   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int DIV_BITS   = 48;
   localparam int Q_BITS     = FRAC_BITS + 5;
   localparam int H_BITS     = 2 * Q_BITS - FRAC_BITS - 1;
   localparam int E_BITS     = FRAC_BITS + 7;
   localparam int G_BITS     = FRAC_BITS + 1;
   localparam int TOTAL_BITS = 56;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // word selects
   localparam logic [SEL_BITS-1:0] W_XCENTRE = 3'd0;
   localparam logic [SEL_BITS-1:0] W_YCENTRE = 3'd1;
   localparam logic [SEL_BITS-1:0] W_XSIGMA  = 3'd2;
   localparam logic [SEL_BITS-1:0] W_YSIGMA  = 3'd3;
   localparam logic [SEL_BITS-1:0] W_COUNT   = 3'd4;
   localparam logic [SEL_BITS-1:0] W_NORM    = 3'd5;

   // divider tags
   localparam logic TAG_FIRST  = 1'b0;
   localparam logic TAG_SECOND = 1'b1;

   // 2^-(j/16) in q30
   localparam logic [30:0] POW2_TAB [17] = '{
      31'd1073741824, 31'd1028218693, 31'd984625594, 31'd942880699,
      31'd902905651,  31'd864625413,  31'd827968133, 31'd792865000,
      31'd759250125,  31'd727060410,  31'd696235435, 31'd666717336,
      31'd638450708,  31'd611382493,  31'd585461880, 31'd560640196,
      31'd536870912
   };

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_RATIO, S_WAIT_RATIO, S_SQUARE, S_LOG, S_INTERP,
      S_GAUSS, S_SCALE, S_DIVIDE, S_WAIT_DIV, S_ACCUM, S_RESULT
   } state_type;

   // one stage of the divider chain
   typedef struct packed {
      logic                 valid;
      logic                 tag;
      logic [WORD_BITS-1:0] rem;
      logic [WORD_BITS-1:0] divisor;
      logic [DIV_BITS-1:0]  dividend;
      logic [DIV_BITS-1:0]  quotient;
   } div_lane_type;

   function automatic logic [ADDR_BITS-1:0] table_addr(
      input logic [COMP_BITS-1:0] comp, input logic [SEL_BITS-1:0] word);
      return ADDR_BITS'(int'(comp) * WORDS_PER + int'(word));
   endfunction

endpackage
`default_nettype wire

### rtl/core/gme_ram.sv
`default_nettype none
module gme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/core/gme_div_cell.sv
`default_nettype none
module gme_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  gme_pkg::div_lane_type up_lane,
   output gme_pkg::div_lane_type down_lane
);
   import gme_pkg::*;

   logic [WORD_BITS:0] trial;
   logic               fits;
   div_lane_type       step_in;
   div_lane_type       lane_ff;
   logic               valid_ff;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial            = {up_lane.rem, up_lane.dividend[DIV_BITS-1]};
      fits             = trial >= {1'b0, up_lane.divisor};
      step_in          = up_lane;
      step_in.rem      = fits ? WORD_BITS'(trial - {1'b0, up_lane.divisor})
                              : trial[WORD_BITS-1:0];
      step_in.dividend = {up_lane.dividend[DIV_BITS-2:0], 1'b0};
      step_in.quotient = {up_lane.quotient[DIV_BITS-2:0], fits};
   end

   // valid flag is control, the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= step_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= step_in;
   end

   always_comb begin
      down_lane       = lane_ff;
      down_lane.valid = valid_ff;
   end
endmodule
`default_nettype wire

### rtl/core/gme_divider.sv
`default_nettype none
module gme_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            tag,
   input  logic [gme_pkg::DIV_BITS-1:0]    dividend,
   input  logic [gme_pkg::WORD_BITS-1:0]   divisor,
   output gme_pkg::div_lane_type           result
);
   import gme_pkg::*;

   div_lane_type lane [DIV_BITS+1];

   // fresh division enters with a clear remainder
   always_comb begin
      lane[0].valid    = start;
      lane[0].tag      = tag;
      lane[0].rem      = '0;
      lane[0].divisor  = divisor;
      lane[0].dividend = dividend;
      lane[0].quotient = '0;
   end

   // one cell per quotient bit
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
      gme_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_lane   (lane[i]),
         .down_lane (lane[i+1])
      );
   end

   assign result = lane[DIV_BITS];
endmodule
`default_nettype wire

### rtl/core/gaussian_mixture_2d_eval.sv
// Gaussian mixture evaluator, 2d, q16.16.
// Input stream (req_): tuser is the opcode. A load transfer writes one
// component word into the table and gives no result; an evaluate transfer
// starts one point, which answers with one rsp_ transfer per active
// component, the last one flagged by rsp_tlast and carrying the final total.
// The block works on one item at a time: req_tready is high only while idle.
// A load is written into the table as it is accepted. For each active
// component an evaluate steps through the table reads, two issue states
// that send the ratios into the 48-cell restoring divider chain, the
// square, exponent and scaling steps, again two issue states and the chain
// for normalisation, one state to accumulate and one to present the result.
// The result sits in an output register; while the receiver holds
// rsp_tready low the block waits with that result and does not move on.
// csr_ sets the active component count (0 acts as 1, above 8 acts as 8);
// write it only while idle. Reset (synchronous, active high) returns the
// sequencer to idle and the count to 1; the component table is not
// cleared, so every word used must be loaded first.
`default_nettype none
`include "assert_macros.svh"
module gaussian_mixture_2d_eval (
   input  logic        clock,
   input  logic        reset,
   // opcode
   input  logic        req_tuser,
   // component_sel, word_sel, load_value, x_coord, y_coord, zero fill
   input  logic [63:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // component_out, derivative, total_value, zero fill
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   import gme_pkg::*;

   // input fields
   logic [COMP_BITS-1:0]  in_comp;
   logic [SEL_BITS-1:0]   in_word;
   logic [WORD_BITS-1:0]  in_value;
   logic [COORD_BITS-1:0] in_x;
   logic [COORD_BITS-1:0] in_y;

   assign in_comp  = req_tdata[2:0];
   assign in_word  = req_tdata[5:3];
   assign in_value = req_tdata[37:6];
   assign in_x     = req_tdata[47:38];
   assign in_y     = req_tdata[57:48];

   // control state
   state_type             state_ff, state_in;
   logic [COMP_BITS-1:0]  comp_ff, comp_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [2:0]            rd_cnt_ff, rd_cnt_in;
   logic                  ph_ff, ph_in;
   logic [3:0]            active_ff, active_in;

   // payload
   logic [WORD_BITS-1:0]  w_ff [WORDS_PER];
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic                  cap_x_ff, cap_y_ff;
   logic [DIV_BITS-1:0]   quo0_ff, quo1_ff;
   logic [H_BITS-1:0]     hx_ff, hy_ff;
   logic [E_BITS-1:0]     t_ff;
   logic [30:0]           v_ff;
   logic [6:0]            n_ff;
   logic [G_BITS-1:0]     g_ff;
   logic [DIV_BITS-1:0]   prod_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [COMP_BITS-1:0]  out_comp_ff;
   logic [WORD_BITS-1:0]  deriv_ff, tot_ff;
   logic                  last_ff;

   // handshakes
   logic accept, load_ok, eval_go, rsp_done, last_comp;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESULT);
   assign accept     = req_tvalid && req_tready;
   assign load_ok    = accept && (req_tuser == OP_LOAD) &&
                       (int'(in_comp) < NUM_COMPONENTS) && (in_word <= W_NORM);
   assign eval_go    = accept && (req_tuser == OP_EVAL);
   assign rsp_done   = rsp_tvalid && rsp_tready;
   assign last_comp  = (LIMIT_BITS'(comp_ff) + LIMIT_BITS'(1)) == limit_ff;

   // component table
   logic [ADDR_BITS-1:0] rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   assign rd_addr = table_addr(comp_ff, rd_cnt_ff);

   gme_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (table_addr(in_comp, in_word)),
      .wr_data (in_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // distances, sigma magnitudes and the ratio cap
   logic [WORD_BITS+1:0] dx, dy;
   logic [WORD_BITS-1:0] dist_x, dist_y, sig_x, sig_y;
   logic                 cap_x, cap_y;

   always_comb begin
      dx     = {{2{w_ff[W_XCENTRE][WORD_BITS-1]}}, w_ff[W_XCENTRE]} -
               (WORD_BITS+2)'({x_ff, FRAC_BITS'(0)});
      dy     = {{2{w_ff[W_YCENTRE][WORD_BITS-1]}}, w_ff[W_YCENTRE]} -
               (WORD_BITS+2)'({y_ff, FRAC_BITS'(0)});
      dist_x = dx[WORD_BITS+1] ? WORD_BITS'(-dx) : dx[WORD_BITS-1:0];
      dist_y = dy[WORD_BITS+1] ? WORD_BITS'(-dy) : dy[WORD_BITS-1:0];
      sig_x  = w_ff[W_XSIGMA][WORD_BITS-1] ? -w_ff[W_XSIGMA] : w_ff[W_XSIGMA];
      sig_y  = w_ff[W_YSIGMA][WORD_BITS-1] ? -w_ff[W_YSIGMA] : w_ff[W_YSIGMA];
      cap_x  = {4'b0, dist_x} >= {sig_x, 4'b0};
      cap_y  = {4'b0, dist_y} >= {sig_y, 4'b0};
   end

   // shared divider chain
   logic                 div_start, div_tag;
   logic [DIV_BITS-1:0]  div_dividend;
   logic [WORD_BITS-1:0] div_divisor;
   div_lane_type         div_out;
   logic [WORD_BITS-1:0] cnt_mag, nrm_mag;

   assign cnt_mag = w_ff[W_COUNT][WORD_BITS-1] ? -w_ff[W_COUNT] : w_ff[W_COUNT];
   assign nrm_mag = w_ff[W_NORM][WORD_BITS-1] ? -w_ff[W_NORM] : w_ff[W_NORM];

   gme_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .tag      (div_tag),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (eval_go) state_in = S_READ;
         S_READ:       if (rd_cnt_ff == 3'(WORDS_PER)) state_in = S_RATIO;
         S_RATIO:      if (ph_ff) state_in = S_WAIT_RATIO;
         S_WAIT_RATIO: if (div_out.valid && div_out.tag == TAG_SECOND) begin
            state_in = S_SQUARE;
         end
         S_SQUARE:     state_in = S_LOG;
         S_LOG:        state_in = S_INTERP;
         S_INTERP:     state_in = S_GAUSS;
         S_GAUSS:      state_in = S_SCALE;
         S_SCALE:      state_in = S_DIVIDE;
         S_DIVIDE:     if (ph_ff) state_in = S_WAIT_DIV;
         S_WAIT_DIV:   if (div_out.valid && div_out.tag == TAG_SECOND) begin
            state_in = S_ACCUM;
         end
         S_ACCUM:      state_in = S_RESULT;
         S_RESULT:     if (rsp_tready) state_in = last_comp ? S_IDLE : S_READ;
         default:      state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: counters and divider issue
   always_comb begin
      comp_in      = comp_ff;
      limit_in     = limit_ff;
      rd_cnt_in    = 3'd0;
      ph_in        = 1'b0;
      div_start    = 1'b0;
      div_tag      = TAG_FIRST;
      div_dividend = {dist_x, FRAC_BITS'(0)};
      div_divisor  = sig_x;
      case (state_ff)
         S_IDLE: begin
            comp_in = '0;
            if (active_ff == 4'd0) begin
               limit_in = LIMIT_BITS'(1);
            end else if (int'(active_ff) > NUM_COMPONENTS) begin
               limit_in = LIMIT_BITS'(NUM_COMPONENTS);
            end else begin
               limit_in = LIMIT_BITS'(active_ff);
            end
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
         end
         S_RATIO: begin
            ph_in     = 1'b1;
            div_start = 1'b1;
            if (ph_ff) begin
               div_tag      = TAG_SECOND;
               div_dividend = {dist_y, FRAC_BITS'(0)};
               div_divisor  = sig_y;
            end
         end
         S_DIVIDE: begin
            ph_in     = 1'b1;
            div_start = 1'b1;
            if (ph_ff) begin
               div_tag      = TAG_SECOND;
               div_dividend = prod_ff;
               div_divisor  = nrm_mag;
            end else begin
               div_dividend = DIV_BITS'({g_ff, FRAC_BITS'(0)});
               div_divisor  = w_ff[W_NORM];
            end
         end
         S_RESULT: begin
            if (rsp_tready) comp_in = comp_ff + COMP_BITS'(1);
         end
         default: begin
         end
      endcase
      active_in = csr_we ? csr_wdata : active_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         comp_ff   <= '0;
         limit_ff  <= LIMIT_BITS'(1);
         rd_cnt_ff <= 3'd0;
         ph_ff     <= 1'b0;
         active_ff <= 4'd1;
      end else begin
         state_ff  <= state_in;
         comp_ff   <= comp_in;
         limit_ff  <= limit_in;
         rd_cnt_ff <= rd_cnt_in;
         ph_ff     <= ph_in;
         active_ff <= active_in;
      end
   end

   // gaussian datapath
   logic [Q_BITS-1:0]        qx, qy;
   logic [2*Q_BITS-1:0]      sq_x, sq_y;
   logic [H_BITS:0]          e_sum;
   logic [E_BITS-1:0]        e_cap;
   logic [E_BITS+30:0]       t_prod;
   logic [3:0]               tab_j;
   logic [FRAC_BITS-5:0]     tab_rem;
   logic [30:0]              tab_diff;
   logic [30+FRAC_BITS-4:0]  interp;
   logic [6:0]               shift;

   always_comb begin
      qx       = cap_x_ff ? Q_BITS'(16 << FRAC_BITS) : quo0_ff[Q_BITS-1:0];
      qy       = cap_y_ff ? Q_BITS'(16 << FRAC_BITS) : quo1_ff[Q_BITS-1:0];
      sq_x     = qx * qx;
      sq_y     = qy * qy;
      e_sum    = {1'b0, hx_ff} + {1'b0, hy_ff};
      e_cap    = (e_sum > (H_BITS+1)'(64 << FRAC_BITS)) ? E_BITS'(64 << FRAC_BITS)
                                                       : e_sum[E_BITS-1:0];
      t_prod   = e_cap * LOG2E_Q30;
      tab_j    = t_ff[FRAC_BITS-1:FRAC_BITS-4];
      tab_rem  = t_ff[FRAC_BITS-5:0];
      tab_diff = POW2_TAB[tab_j] - POW2_TAB[5'(tab_j) + 5'd1];
      interp   = tab_diff * tab_rem;
      shift    = 7'(30 - FRAC_BITS) + n_ff;
   end

   // result datapath
   logic [WORD_BITS-1:0]  deriv_in, tot_in;
   logic [TOTAL_BITS-1:0] term_in, total_in;
   logic                  neg_term;

   always_comb begin
      if (w_ff[W_NORM][WORD_BITS-1]) begin
         deriv_in = '0;
      end else if (w_ff[W_NORM] == '0) begin
         deriv_in = (g_ff != '0) ? '1 : '0;
      end else if (quo0_ff[DIV_BITS-1:WORD_BITS] != '0) begin
         deriv_in = '1;
      end else begin
         deriv_in = quo0_ff[WORD_BITS-1:0];
      end
      neg_term = w_ff[W_COUNT][WORD_BITS-1] ^ w_ff[W_NORM][WORD_BITS-1];
      if (nrm_mag == '0) begin
         if (prod_ff == '0) begin
            term_in = '0;
         end else if (w_ff[W_COUNT][WORD_BITS-1]) begin
            term_in = -(TOTAL_BITS'(1) << 33);
         end else begin
            term_in = TOTAL_BITS'(1) << 33;
         end
      end else begin
         term_in = neg_term ? -TOTAL_BITS'(quo1_ff) : TOTAL_BITS'(quo1_ff);
      end
      total_in = total_ff + term_in;
      if (total_in[TOTAL_BITS-1]) begin
         tot_in = '0;
      end else if (total_in[TOTAL_BITS-2:WORD_BITS] != '0) begin
         tot_in = '1;
      end else begin
         tot_in = total_in[WORD_BITS-1:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (eval_go) begin
         x_ff     <= in_x;
         y_ff     <= in_y;
         total_ff <= '0;
      end
      if (state_ff == S_READ && rd_cnt_ff != 3'd0) begin
         w_ff[rd_cnt_ff - 3'd1] <= rd_data;
      end
      if (state_ff == S_RATIO) begin
         if (ph_ff) cap_y_ff <= cap_y;
         else       cap_x_ff <= cap_x;
      end
      if (div_out.valid) begin
         if (div_out.tag == TAG_SECOND) quo1_ff <= div_out.quotient;
         else                           quo0_ff <= div_out.quotient;
      end
      if (state_ff == S_SQUARE) begin
         hx_ff <= sq_x[2*Q_BITS-1:FRAC_BITS+1];
         hy_ff <= sq_y[2*Q_BITS-1:FRAC_BITS+1];
      end
      if (state_ff == S_LOG) begin
         t_ff <= t_prod[E_BITS+29:30];
      end
      if (state_ff == S_INTERP) begin
         v_ff <= POW2_TAB[tab_j] - 31'(interp >> (FRAC_BITS - 4));
         n_ff <= 7'(t_ff >> FRAC_BITS);
      end
      if (state_ff == S_GAUSS) begin
         g_ff <= G_BITS'(v_ff >> shift);
      end
      if (state_ff == S_SCALE) begin
         prod_ff <= DIV_BITS'(cnt_mag * g_ff);
      end
      if (state_ff == S_ACCUM) begin
         total_ff    <= total_in;
         out_comp_ff <= comp_ff;
         deriv_ff    <= deriv_in;
         tot_ff      <= tot_in;
         last_ff     <= last_comp;
      end
   end

   assign rsp_tdata = {5'b0, tot_ff, deriv_ff, out_comp_ff};
   assign rsp_tlast = last_ff;

   // checks
   `ASSERT_IMPLIES(a_one_item, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_IMPLIES(a_div_when_waiting, clock, reset, div_out.valid,
                   (state_ff == S_WAIT_RATIO) || (state_ff == S_WAIT_DIV))
   `ASSERT_NEXT(a_last_frees_input, clock, reset,
                rsp_tvalid && rsp_tready && rsp_tlast, req_tready)
endmodule
`default_nettype wire

### verif/tb_gaussian_mixture_2d_eval.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_gaussian_mixture_2d_eval;
   import gme_pkg::*;

   localparam int IDLE_LIMIT = 30000;
   localparam int HOLD_CYCLES = 4000;

   typedef struct packed {
      logic [2:0]  comp;
      logic [31:0] deriv;
      logic [31:0] total;
      logic        last;
   } point_result_type;

   // mixture predictor and store of pending component results
   class mixture_scoreboard;
      logic [31:0] words [TABLE_DEPTH];
      logic [3:0] active_setting;
      point_result_type pending [$];
      int mismatches;

      function new();
         active_setting = 4'd1;
         mismatches = 0;
      endfunction

      function longint unsigned mag(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      function longint unsigned half_square(longint unsigned d, longint unsigned s);
         longint unsigned q;
         if (d >= s * 16) q = 64'd16 << FRAC_BITS;
         else q = (d << FRAC_BITS) / s;
         return (q * q) >> (FRAC_BITS + 1);
      endfunction

      function longint unsigned neg_exp(longint unsigned e);
         longint unsigned t, n, f, rem, v, sh, hi, lo;
         int j;
         if (e > (64'd64 << FRAC_BITS)) e = 64'd64 << FRAC_BITS;
         t = (e * longint'(LOG2E_Q30)) >> 30;
         n = t >> FRAC_BITS;
         f = t & ((64'd1 << FRAC_BITS) - 1);
         j = int'((f >> (FRAC_BITS - 4)) & 15);
         rem = f & ((64'd1 << (FRAC_BITS - 4)) - 1);
         hi = POW2_TAB[j];
         lo = POW2_TAB[j + 1];
         v = hi - (((hi - lo) * rem) >> (FRAC_BITS - 4));
         sh = (30 - FRAC_BITS) + n;
         if (sh >= 63) return 0;
         return v >> sh;
      endfunction

      // accepted request: table write or point evaluation
      function void note_request(logic op, logic [63:0] d);
         logic [2:0] c, w;
         longint px, py, cnt, nrm, total, term;
         longint unsigned e, g, deriv, prod;
         point_result_type r;
         int lim;
         c = d[2:0];
         w = d[5:3];
         if (op == OP_LOAD) begin
            if (w < WORDS_PER) words[c * WORDS_PER + w] = d[37:6];
            return;
         end
         px = longint'(d[47:38]) << FRAC_BITS;
         py = longint'(d[57:48]) << FRAC_BITS;
         lim = (active_setting == 0) ? 1 : (active_setting > 8 ? 8 : active_setting);
         total = 0;
         for (int k = 0; k < lim; k++) begin
            cnt = longint'($signed(words[k * WORDS_PER + W_COUNT]));
            nrm = longint'($signed(words[k * WORDS_PER + W_NORM]));
            e = half_square(mag(longint'($signed(words[k * WORDS_PER + W_XCENTRE])) - px),
                            mag(longint'($signed(words[k * WORDS_PER + W_XSIGMA]))))
              + half_square(mag(longint'($signed(words[k * WORDS_PER + W_YCENTRE])) - py),
                            mag(longint'($signed(words[k * WORDS_PER + W_YSIGMA]))));
            g = neg_exp(e);
            if (nrm < 0) deriv = 0;
            else if (nrm == 0) deriv = (g != 0) ? 64'hFFFF_FFFF : 0;
            else begin
               deriv = (g << FRAC_BITS) / longint'(nrm);
               if (deriv > 64'hFFFF_FFFF) deriv = 64'hFFFF_FFFF;
            end
            prod = mag(cnt) * g;
            if (nrm == 0) begin
               if (prod == 0) term = 0;
               else term = (cnt < 0) ? -(64'sd1 <<< 33) : (64'sd1 <<< 33);
            end else begin
               term = longint'(prod / mag(nrm));
               if ((cnt < 0) != (nrm < 0)) term = -term;
            end
            total += term;
            r.comp = k[2:0];
            r.deriv = deriv[31:0];
            r.total = (total < 0) ? 32'd0 : ((total > 64'sh FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                         : total[31:0]);
            r.last = (k + 1 == lim);
            pending = {pending, r};
         end
      endfunction

      function void check_result(point_result_type got);
         point_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected comp %0d deriv %h total %h last %b,",
                        want.comp, want.deriv, want.total, want.last,
                        " got comp %0d deriv %h total %h last %b",
                        got.comp, got.deriv, got.total, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tuser = 1'b0;
   logic [63:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] rsp_tdata;
   logic rsp_tlast, rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [3:0] csr_wdata = '0;

   mixture_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int idle_cycles = 0;

   gaussian_mixture_2d_eval dut (.*);

   always #6 clock = ~clock;

   // result transfers go to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[66:35], rsp_tlast});
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver with random stall bursts and one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic send(input logic op, input logic [63:0] d);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, d);
   endtask

   task automatic load_word(input int c, input logic [2:0] w, input logic [31:0] v);
      send(OP_LOAD, {6'(0), 10'($urandom), 10'($urandom), v, w, 3'(c)});
   endtask

   task automatic eval_point(input int x, input int y);
      send(OP_EVAL, {6'(0), 10'(y), 10'(x), 32'($urandom), 3'($urandom), 3'($urandom)});
   endtask

   // write the count register once all results are in and the block is idle
   task automatic set_active(input logic [3:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.active_setting = v;
   endtask

   function automatic logic [31:0] plain_word(logic [2:0] w);
      case (w)
         W_XCENTRE, W_YCENTRE: return {6'd0, 10'($urandom), 16'($urandom)};
         W_XSIGMA, W_YSIGMA: begin
            logic [31:0] s;
            s = $urandom_range(32'h0000_8000, 32'h012C_0000);
            return ($urandom_range(0, 5) == 0) ? -s : s;
         end
         W_COUNT: return ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 32'h0032_0000)
                                                      : $urandom_range(0, 32'h0032_0000);
         default: return $urandom_range(32'h0000_0100, 32'h0008_0000);
      endcase
   endfunction

   function automatic int near(logic [31:0] centre);
      int v;
      v = int'(centre[25:16]) + $urandom_range(0, 40) - 20;
      return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
   endfunction

   initial begin
      logic [3:0] settings [8];
      int k, c;
      logic [2:0] w;
      settings = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd8};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table before anything reads it
      for (c = 0; c < NUM_COMPONENTS; c++)
         for (int j = 0; j < WORDS_PER; j++) load_word(c, 3'(j), plain_word(3'(j)));

      // directed: special components and extreme points
      set_active(4'd8);
      load_word(0, W_XSIGMA, 32'd0);
      load_word(1, W_YSIGMA, 32'hFFF0_0000);
      load_word(2, W_NORM, 32'd0);
      load_word(3, W_NORM, 32'hFFFF_0000);
      load_word(4, W_COUNT, 32'h8000_0000);
      load_word(5, W_NORM, 32'd1);
      load_word(5, W_COUNT, 32'h7FFF_FFFF);
      load_word(6, W_NORM, 32'd0);
      load_word(6, W_COUNT, 32'd0);
      load_word(7, W_XCENTRE, 32'h7FFF_FFFF);
      load_word(7, 3'd6, 32'hFFFF_FFFF);
      load_word(7, 3'd7, 32'h1234_5678);
      eval_point(0, 0);
      eval_point(1023, 1023);
      eval_point(0, 1023);
      for (c = 0; c < NUM_COMPONENTS; c++)
         eval_point(near(sb.words[c * WORDS_PER]), near(sb.words[c * WORDS_PER + 1]));

      // random phases across count settings
      for (int p = 0; p < 8; p++) begin
         set_active(settings[p]);
         for (int i = 0; i < 52; i++) begin
            k = p * 52 + i;
            if (k == 100) hold_request = 1'b1;
            if (k > 360) quiet = 1'b1;
            if ($urandom_range(0, 9) < 3) begin
               c = $urandom_range(0, 7);
               w = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
               load_word(c, w, ($urandom_range(0, 9) == 0) ? 32'($urandom) : plain_word(w));
            end else if ($urandom_range(0, 9) < 7) begin
               c = $urandom_range(0, 7);
               eval_point(near(sb.words[c * WORDS_PER]), near(sb.words[c * WORDS_PER + 1]));
            end else
               eval_point($urandom_range(0, 1023), $urandom_range(0, 1023));
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
